@@ hdl/circular_double_ended_queue_macros.svh @@
// Assertion macros for the circular double-ended queue.
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_MACROS_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CDEQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deque check failed");

// Next-cycle implication, checked outside reset.
`define CDEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deque check failed");

`endif

@@ hdl/cdeq_pkg.sv @@
// Shared types and codes for the circular double-ended queue.
`timescale 1ns / 1ps
package cdeq_pkg;

	localparam int DATA_W = 32;

	// Operation codes on func
	localparam logic [1:0] FN_PUSH_FRONT = 2'd0;
	localparam logic [1:0] FN_PUSH_REAR  = 2'd1;
	localparam logic [1:0] FN_POP_FRONT  = 2'd2;
	localparam logic [1:0] FN_POP_REAR   = 2'd3;

	// Status codes
	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_EMPTY     = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RESP = 2'b10
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic exec;
		logic load;
	} cmd_t;

endpackage

@@ hdl/cdeq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cdeq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hdl/cdeq_ctrl.sv @@
// Controller state machine for the circular double-ended queue.
`timescale 1ns / 1ps
module cdeq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output cdeq_pkg::cmd_t cmd
);

	cdeq_pkg::state_t state_q, state_d;
	logic             out_valid_q;

	assign in_ready  = (state_q == cdeq_pkg::S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		case (state_q)
			cdeq_pkg::S_IDLE: begin
				cmd.exec = in_valid;
				if (in_valid) begin
					state_d = cdeq_pkg::S_RESP;
				end
			end
			cdeq_pkg::S_RESP: begin
				// hold until the output register is free
				cmd.load = !out_valid_q || out_ready;
				if (cmd.load) begin
					state_d = cdeq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = cdeq_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cdeq_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ hdl/cdeq_dpath.sv @@
// Datapath: indices, empty flag, entry store and output register.
`timescale 1ns / 1ps
module cdeq_dpath #(
	parameter int DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  cdeq_pkg::cmd_t                     cmd,
	input  logic [1:0]                         func,
	input  logic signed [cdeq_pkg::DATA_W-1:0] push_data,
	output logic signed [cdeq_pkg::DATA_W-1:0] pop_data,
	output logic [1:0]                         status,
	output logic                               now_empty,
	output logic                               now_full
);

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [AW-1:0] head_q, tail_q, head_d, tail_d;
	logic          empty_q, empty_d;
	logic [1:0]    status_q, status_d;
	logic          pop_ok_q;
	logic          full;
	logic          is_push;
	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [cdeq_pkg::DATA_W-1:0] rdata;
	logic [cdeq_pkg::DATA_W-1:0] res_data;

	logic signed [cdeq_pkg::DATA_W-1:0] pop_data_q;
	logic [1:0]                         out_status_q;
	logic                               now_empty_q, now_full_q;

	function automatic logic [AW-1:0] step_up(input logic [AW-1:0] i);
		return (i == LAST) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [AW-1:0] step_down(input logic [AW-1:0] i);
		return (i == '0) ? LAST : i - 1'b1;
	endfunction

	assign full    = !empty_q && (step_up(tail_q) == head_q);
	assign is_push = (func == cdeq_pkg::FN_PUSH_FRONT) || (func == cdeq_pkg::FN_PUSH_REAR);

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		empty_d  = empty_q;
		status_d = cdeq_pkg::ST_DONE;
		we       = 1'b0;
		re       = 1'b0;
		waddr    = '0;
		raddr    = (func == cdeq_pkg::FN_POP_FRONT) ? head_q : tail_q;
		if (cmd.exec) begin
			if (is_push) begin
				if (full) begin
					status_d = cdeq_pkg::ST_FULL;
				end else if (empty_q) begin
					// first entry always lands in slot zero
					head_d  = '0;
					tail_d  = '0;
					empty_d = 1'b0;
					we      = 1'b1;
				end else if (func == cdeq_pkg::FN_PUSH_FRONT) begin
					head_d = step_down(head_q);
					waddr  = head_d;
					we     = 1'b1;
				end else begin
					tail_d = step_up(tail_q);
					waddr  = tail_d;
					we     = 1'b1;
				end
			end else begin
				if (empty_q) begin
					status_d = cdeq_pkg::ST_EMPTY;
				end else begin
					re = 1'b1;
					if (head_q == tail_q) begin
						// last entry out: back to the empty layout
						empty_d = 1'b1;
						head_d  = '0;
						tail_d  = '0;
					end else if (func == cdeq_pkg::FN_POP_FRONT) begin
						head_d = step_up(head_q);
					end else begin
						tail_d = step_down(tail_q);
					end
				end
			end
		end
	end

	cdeq_ram #(
		.WIDTH(cdeq_pkg::DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(push_data),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
		end else begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			empty_q <= empty_d;
		end
	end

	// per-item result held between exec and load
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= status_d;
			pop_ok_q <= re;
		end
	end

	always_comb begin
		if (pop_ok_q) begin
			res_data = rdata;
		end else if (status_q == cdeq_pkg::ST_EMPTY) begin
			res_data = '1;
		end else begin
			res_data = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pop_data_q   <= res_data;
			out_status_q <= status_q;
			now_empty_q  <= empty_q;
			now_full_q   <= full;
		end
	end

	assign pop_data  = pop_data_q;
	assign status    = out_status_q;
	assign now_empty = now_empty_q;
	assign now_full  = now_full_q;

endmodule

@@ hdl/circular_double_ended_queue.sv @@
// An accepted word has its result registered at the store's read port and in the status register,
// then in the output register once that is free; no new word is taken until that load is done.
// The output register lets the next word in while a result waits to be taken.
// Reset (arst_n low) empties the queue at once; stored words are not cleared.
`timescale 1ns / 1ps
`include "circular_double_ended_queue_macros.svh"
module circular_double_ended_queue #(
	parameter int DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         func,
	input  logic signed [cdeq_pkg::DATA_W-1:0] push_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [cdeq_pkg::DATA_W-1:0] pop_data,
	output logic [1:0]                         status,
	output logic                               now_empty,
	output logic                               now_full
);

	cdeq_pkg::cmd_t cmd;

	cdeq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd)
	);

	cdeq_dpath #(
		.DEPTH(DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.func     (func),
		.push_data(push_data),
		.pop_data (pop_data),
		.status   (status),
		.now_empty(now_empty),
		.now_full (now_full)
	);

	`CDEQ_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`CDEQ_ASSERT_NOW(a_refused_pop_ones, clk, arst_n,
		out_valid && status == cdeq_pkg::ST_EMPTY, pop_data == '1 && now_empty)
	`CDEQ_ASSERT_NOW(a_refused_push_full, clk, arst_n,
		out_valid && status == cdeq_pkg::ST_FULL, now_full && !now_empty && pop_data == '0)

endmodule
